/* hdl/quad_attitude_pid_mixer_defines.svh */
// Assertion macros for the attitude controller.
`ifndef QUAD_ATTITUDE_PID_MIXER_DEFINES_SVH
`define QUAD_ATTITUDE_PID_MIXER_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define QAPM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define QAPM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define QAPM_ASSERT(label, clk, rst_n, prop, msg)
`define QAPM_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

/* hdl/qapm_pkg.sv */
// Shared types and constants for the attitude controller.
package qapm_pkg;
  localparam int unsigned PulseW = 12;
  localparam int unsigned AngleW = 9;
  localparam int unsigned ErrW   = 10;
  localparam int unsigned YawW   = 11;
  localparam int unsigned MsW    = 10;
  localparam int unsigned GainW  = 16;
  localparam int unsigned DriveW = 16;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] RegPropGain  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegIntegGain = 3'd1;
  localparam logic [CfgIdxW-1:0] RegDerivGain = 3'd2;
  localparam logic [CfgIdxW-1:0] RegMinPulse  = 3'd3;
  localparam logic [CfgIdxW-1:0] RegMaxPulse  = 3'd4;

  localparam logic [PulseW-1:0] MinPulseRst = 12'd1000;
  localparam logic [PulseW-1:0] MaxPulseRst = 12'd1700;

  // serial unit commands
  typedef enum logic [1:0] {
    OpMul = 2'd0,
    OpDiv = 2'd1
  } op_e;

  typedef enum logic [3:0] {
    StIdle, StLoadP, StMulP, StLoadI, StMulI, StDivI,
    StLoadD, StMulD, StDivD, StSum, StDivG, StNext, StMix, StOut
  } state_e;

  typedef struct packed {
    logic start;
    op_e  op;
  } su_cmd_t;
endpackage

/* hdl/quad_attitude_pid_mixer.sv */
// Top level: two PID loops on a shared serial unit, then an X-frame mixer.
//   channel | signals                               | direction
//   in      | in_valid_i / in_ready_o, 7 fields      | in
//   out     | out_valid_o / out_ready_i, 6 fields    | out
//   cfg     | cfg_valid_i / cfg_ready_o, idx, data   | in
// From the accepting edge, each loop (pitch, then roll) runs five serial
// operations, each stepping through all 64 bits, and six control states;
// then one mix state and one output state raise out_valid. A low out_ready
// holds the word in the result register until it is taken.
// Reset clears gains to zero, pulse limits to 1000 and 1700, and loop state.
// The result register holds until taken; a new word is taken once it is empty.
module quad_attitude_pid_mixer import qapm_pkg::*; #(
  parameter int unsigned GAIN_FRAC_BITS = 8,
  parameter int unsigned INTEGRAL_WIDTH = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [PulseW-1:0]      throttle_i,
  input  logic signed [AngleW-1:0] pitch_target_i,
  input  logic signed [AngleW-1:0] pitch_angle_i,
  input  logic signed [AngleW-1:0] roll_target_i,
  input  logic signed [AngleW-1:0] roll_angle_i,
  input  logic signed [YawW-1:0] yaw_correction_i,
  input  logic [MsW-1:0]         elapsed_ms_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [PulseW-1:0]      motor_a_o,
  output logic [PulseW-1:0]      motor_b_o,
  output logic [PulseW-1:0]      motor_c_o,
  output logic [PulseW-1:0]      motor_d_o,
  output logic signed [DriveW-1:0] pitch_drive_o,
  output logic signed [DriveW-1:0] roll_drive_o,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CfgIdxW-1:0]     cfg_idx_i,
  input  logic [GainW-1:0]       cfg_data_i
);
  localparam int unsigned W  = 64;
  localparam int unsigned IW = INTEGRAL_WIDTH;
  localparam logic signed [IW-1:0] IHi = {1'b0, {(IW-1){1'b1}}};
  localparam logic signed [IW-1:0] ILo = {1'b1, {(IW-1){1'b0}}};

  // configuration registers
  logic [GainW-1:0]  kp_q, ki_q, kd_q;
  logic [PulseW-1:0] minp_q, maxp_q;
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_q <= '0; ki_q <= '0; kd_q <= '0;
      minp_q <= MinPulseRst; maxp_q <= MaxPulseRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_i)
        RegPropGain:  kp_q   <= cfg_data_i;
        RegIntegGain: ki_q   <= cfg_data_i;
        RegDerivGain: kd_q   <= cfg_data_i;
        RegMinPulse:  minp_q <= cfg_data_i[PulseW-1:0];
        RegMaxPulse:  maxp_q <= cfg_data_i[PulseW-1:0];
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;
  logic loop_q, loop_d;   // 0 pitch, 1 roll
  su_cmd_t cmd;
  logic su_busy;
  logic [W-1:0] su_a, su_b, su_res;
  logic signed [W-1:0] sum_q, sum_d;
  logic neg_q, neg_d;
  logic out_valid_q;

  // captured word
  logic [PulseW-1:0] thr_q;
  logic signed [YawW-1:0] yaw_q;
  logic [MsW-1:0] ms_q;
  logic signed [ErrW-1:0] err_q [2];
  logic signed [ErrW-1:0] prev_q [2];
  logic signed [IW-1:0] integ_q [2];
  logic signed [DriveW-1:0] drv_q [2];
  logic [PulseW-1:0] mot_q [4];

  logic signed [ErrW-1:0] e_cur, p_cur;
  logic signed [ErrW:0] de, se;
  logic signed [IW+12:0] a_new;
  logic signed [IW-1:0] a_sat;
  logic signed [W-1:0] res_s;

  qapm_serial_unit #(.W(W)) u_su (
    .clk_i, .rst_ni, .cmd_i(cmd), .a_i(su_a), .b_i(su_b),
    .busy_o(su_busy), .res_o(su_res)
  );

  assign e_cur = err_q[loop_q];
  assign p_cur = prev_q[loop_q];
  assign de = {e_cur[ErrW-1], e_cur} - {p_cur[ErrW-1], p_cur};
  assign se = {e_cur[ErrW-1], e_cur} + {p_cur[ErrW-1], p_cur};
  assign a_new = (IW+13)'(integ_q[loop_q]) + (IW+13)'(se) * $signed({1'b0, ms_q});
  assign a_sat = (a_new > (IW+13)'(IHi)) ? IHi :
                 (a_new < (IW+13)'(ILo)) ? ILo : a_new[IW-1:0];
  assign res_s = neg_q ? -$signed(su_res) : $signed(su_res);

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StIdle:  if (in_valid_i && !out_valid_q) state_d = StLoadP;
      StLoadP: state_d = StMulP;
      StMulP:  if (!su_busy) state_d = StLoadI;
      StLoadI: state_d = StMulI;
      StMulI:  if (!su_busy) state_d = StDivI;
      StDivI:  if (!su_busy) state_d = StLoadD;
      StLoadD: state_d = StMulD;
      StMulD:  if (!su_busy) state_d = StDivD;
      StDivD:  if (!su_busy) state_d = StSum;
      StSum:   state_d = StDivG;
      StDivG:  state_d = StNext;
      StNext:  state_d = loop_q ? StMix : StLoadP;
      StMix:   state_d = StOut;
      StOut:   state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // serial unit commands and operands
  always_comb begin
    cmd = '{start: 1'b0, op: OpMul};
    su_a = '0;
    su_b = '0;
    unique case (state_q)
      StLoadP: begin
        cmd = '{start: 1'b1, op: OpMul};
        su_a = W'(e_cur[ErrW-1] ? -e_cur : e_cur);
        su_b = W'(kp_q);
      end
      StLoadI: begin
        cmd = '{start: 1'b1, op: OpMul};
        su_a = W'(a_sat[IW-1] ? -a_sat : a_sat);
        su_b = W'(ki_q);
      end
      StMulI: if (!su_busy) begin
        cmd = '{start: 1'b1, op: OpDiv};
        su_a = su_res;
        su_b = W'(2000);
      end
      StLoadD: begin
        cmd = '{start: 1'b1, op: OpMul};
        su_a = W'(de[ErrW] ? -de : de);
        su_b = W'(kd_q) * W'(1000);
      end
      StMulD: if (!su_busy) begin
        cmd = '{start: 1'b1, op: OpDiv};
        su_a = su_res;
        su_b = W'(ms_q);
      end
      default: ;
    endcase
  end

  // accumulate signed terms and sign tracking
  always_comb begin
    sum_d = sum_q;
    neg_d = neg_q;
    loop_d = loop_q;
    unique case (state_q)
      StIdle:  loop_d = 1'b0;
      StLoadP: begin neg_d = e_cur[ErrW-1]; sum_d = '0; end
      StMulP:  if (!su_busy) sum_d = sum_q + res_s;
      StLoadI: neg_d = a_sat[IW-1];
      StDivI:  if (!su_busy) sum_d = sum_q + res_s;
      StLoadD: neg_d = de[ErrW];
      StDivD:  if (!su_busy && ms_q != '0) sum_d = sum_q + res_s;
      StNext:  loop_d = 1'b1;
      default: ;
    endcase
  end

  logic signed [W-1:0] q_g;
  assign q_g = (sum_q < 0) ? -((-sum_q) >>> GAIN_FRAC_BITS) : (sum_q >>> GAIN_FRAC_BITS);

  // mixer
  logic signed [PulseW+DriveW+2:0] mix [4];
  logic signed [PulseW+DriveW+2:0] t_x, p_x, r_x, y_x;
  always_comb begin
    t_x = $signed({1'b0, thr_q});
    p_x = drv_q[0];
    r_x = drv_q[1];
    y_x = yaw_q;
    mix[0] = t_x - p_x - r_x + y_x;
    mix[1] = t_x - p_x + r_x - y_x;
    mix[2] = t_x + p_x - r_x - y_x;
    mix[3] = t_x + p_x + r_x + y_x;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      loop_q <= 1'b0;
      out_valid_q <= 1'b0;
      prev_q[0] <= '0; prev_q[1] <= '0;
      integ_q[0] <= '0; integ_q[1] <= '0;
    end else begin
      state_q <= state_d;
      loop_q <= loop_d;
      if (state_q == StOut) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
      if (state_q == StLoadI) integ_q[loop_q] <= a_sat;
      if (state_q == StNext) prev_q[loop_q] <= e_cur;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    neg_q <= neg_d;
    if (state_q == StIdle && in_valid_i && !out_valid_q) begin
      thr_q <= throttle_i;
      yaw_q <= yaw_correction_i;
      ms_q <= elapsed_ms_i;
      err_q[0] <= ErrW'(pitch_target_i) - ErrW'(pitch_angle_i);
      err_q[1] <= ErrW'(roll_target_i) - ErrW'(roll_angle_i);
    end
    if (state_q == StDivG) begin
      drv_q[loop_q] <= (q_g > 32767) ? 16'sh7fff :
                       (q_g < -32768) ? 16'sh8000 : q_g[DriveW-1:0];
    end
    if (state_q == StMix) begin
      for (int k = 0; k < 4; k++) begin
        mot_q[k] <= (mix[k] < $signed({1'b0, minp_q})) ? minp_q :
                    (mix[k] > $signed({1'b0, maxp_q})) ? maxp_q : mix[k][PulseW-1:0];
      end
    end
  end

  assign in_ready_o   = (state_q == StIdle) && !out_valid_q;
  assign out_valid_o  = out_valid_q;
  assign motor_a_o    = mot_q[0];
  assign motor_b_o    = mot_q[1];
  assign motor_c_o    = mot_q[2];
  assign motor_d_o    = mot_q[3];
  assign pitch_drive_o = drv_q[0];
  assign roll_drive_o  = drv_q[1];

  `include "quad_attitude_pid_mixer_defines.svh"
  `QAPM_ASSERT(a_ready_idle, clk_i, rst_ni, !(in_ready_o && state_q != StIdle), "ready busy")
  `QAPM_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_q && !out_ready_i, out_valid_q, "drop")
  `QAPM_ASSERT(a_no_ready_out, clk_i, rst_ni, !(out_valid_q && in_ready_o), "overlap")
endmodule

/* hdl/qapm_serial_unit.sv */
// Bit-serial shift-add multiplier and restoring divider on magnitudes.
module qapm_serial_unit import qapm_pkg::*; #(
  parameter int unsigned W = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  su_cmd_t      cmd_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  output logic         busy_o,
  output logic [W-1:0] res_o
);
  localparam int unsigned CntW = $clog2(W + 1);

  logic [W-1:0]    acc_q, acc_d, sh_q, sh_d, b_q, b_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  op_e             op_q, op_d;
  logic [W:0]      trial;
  logic [W-1:0]    rem_sh;

  // one bit per cycle
  always_comb begin
    acc_d  = acc_q;
    sh_d   = sh_q;
    b_d    = b_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    op_d   = op_q;
    rem_sh = {acc_q[W-2:0], sh_q[W-1]};
    trial  = {1'b0, rem_sh} - {1'b0, b_q};
    if (cmd_i.start) begin
      acc_d  = '0;
      sh_d   = a_i;
      b_d    = b_i;
      cnt_d  = CntW'(W);
      busy_d = 1'b1;
      op_d   = cmd_i.op;
    end else if (busy_q) begin
      if (op_q == OpMul) begin
        // multiplier bits enter from the LSB of sh
        if (sh_q[0]) acc_d = acc_q + b_q;
        sh_d = sh_q >> 1;
        b_d  = b_q << 1;
      end else begin
        sh_d = {sh_q[W-2:0], ~trial[W]};
        acc_d = trial[W] ? rem_sh : trial[W-1:0];
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= OpMul;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    sh_q  <= sh_d;
    b_q   <= b_d;
  end

  assign busy_o = busy_q;
  assign res_o  = (op_q == OpMul) ? acc_q : sh_q;

  `include "quad_attitude_pid_mixer_defines.svh"
  `QAPM_ASSERT(a_no_start_busy, clk_i, rst_ni, !(cmd_i.start && busy_q), "start while busy")
  `QAPM_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, cmd_i.start, busy_q, "busy not set")
  `QAPM_ASSERT(a_cnt_busy, clk_i, rst_ni, !busy_q || cnt_q != '0, "busy with zero count")
endmodule

/* tb/tb.sv */
// Testbench for the attitude controller: PID loops, X mixer and pulse clamps.
`timescale 1ns / 1ps
module tb;
  import qapm_pkg::*;

  localparam int unsigned IntegW    = 32;
  localparam int unsigned GainFrac  = 8;
  localparam int unsigned IdleLimit = 20000;

  typedef struct {
    logic [PulseW-1:0]        thr;
    logic signed [AngleW-1:0] pt, pa, rt, ra;
    logic signed [YawW-1:0]   yaw;
    logic [MsW-1:0]           ms;
  } tick_t;

  typedef struct {
    logic [PulseW-1:0]        m[4];
    logic signed [DriveW-1:0] pd, rd;
  } motors_t;

  // Predict motor words from ticks and compare against the block.
  class attitude_board;
    longint unsigned kp, ki, kd, pmin, pmax;
    longint prev_err[2], integ[2];
    motors_t pending[$];
    int unsigned mismatches;

    function new();
      kp = 0; ki = 0; kd = 0; pmin = 1000; pmax = 1700;
      prev_err = '{0, 0}; integ = '{0, 0};
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] val);
      case (idx)
        RegPropGain:  kp = val;
        RegIntegGain: ki = val;
        RegDerivGain: kd = val;
        RegMinPulse:  pmin = val[PulseW-1:0];
        RegMaxPulse:  pmax = val[PulseW-1:0];
        default: ;
      endcase
    endfunction

    function longint pid(int ax, longint err, longint ms);
      longint hi, lo, p, d, i, a, tot;
      hi = (longint'(1) <<< (IntegW - 1)) - 1;
      lo = -hi - 1;
      p = longint'(kp) * err;
      d = 0;
      if (ms != 0) d = (longint'(kd) * (err - prev_err[ax]) * 1000) / ms;
      a = integ[ax] + (prev_err[ax] + err) * ms;
      if (a > hi) a = hi;
      if (a < lo) a = lo;
      integ[ax] = a;
      i = (a * longint'(ki)) / 2000;
      prev_err[ax] = err;
      tot = (p + i + d) / (longint'(1) <<< GainFrac);
      if (tot > 32767) tot = 32767;
      if (tot < -32768) tot = -32768;
      return tot;
    endfunction

    function logic [PulseW-1:0] clamp(longint v);
      if (v < longint'(pmin)) return pmin[PulseW-1:0];
      if (v > longint'(pmax)) return pmax[PulseW-1:0];
      return v[PulseW-1:0];
    endfunction

    function void note_tick(tick_t t);
      longint pd, rd, th, y;
      motors_t r;
      pd = pid(0, longint'(t.pt) - longint'(t.pa), longint'(t.ms));
      rd = pid(1, longint'(t.rt) - longint'(t.ra), longint'(t.ms));
      th = t.thr; y = t.yaw;
      r.m[0] = clamp(th - pd - rd + y);
      r.m[1] = clamp(th - pd + rd - y);
      r.m[2] = clamp(th + pd - rd - y);
      r.m[3] = clamp(th + pd + rd + y);
      r.pd = pd[DriveW-1:0];
      r.rd = rd[DriveW-1:0];
      pending.push_back(r);
    endfunction

    function void check_word(motors_t got);
      motors_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output word");
        return;
      end
      want = pending.pop_front();
      if (got.m != want.m || got.pd != want.pd || got.rd != want.rd) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp %0d %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d %0d",
                   want.m[0], want.m[1], want.m[2], want.m[3], want.pd, want.rd,
                   got.m[0], got.m[1], got.m[2], got.m[3], got.pd, got.rd);
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [PulseW-1:0] throttle_i = '0;
  logic signed [AngleW-1:0] pitch_target_i = '0, pitch_angle_i = '0;
  logic signed [AngleW-1:0] roll_target_i = '0, roll_angle_i = '0;
  logic signed [YawW-1:0] yaw_correction_i = '0;
  logic [MsW-1:0] elapsed_ms_i = 10'd1;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [PulseW-1:0] motor_a_o, motor_b_o, motor_c_o, motor_d_o;
  logic signed [DriveW-1:0] pitch_drive_o, roll_drive_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [GainW-1:0] cfg_data_i = '0;

  attitude_board board = new();
  int unsigned idle_cycles = 0;
  bit stall_en = 1'b1;

  quad_attitude_pid_mixer dut (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sample the output side and stall on a pattern of its own.
  always @(posedge clk_i) begin
    motors_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.m = '{motor_a_o, motor_b_o, motor_c_o, motor_d_o};
      got.pd = pitch_drive_o;
      got.rd = roll_drive_o;
      board.check_word(got);
    end
    if (!stall_en) out_ready_i <= 1'b1;
    else out_ready_i <= ($urandom_range(0, 7) < 5);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else if (idle_cycles >= IdleLimit) begin
      $display("FAIL");
      $finish;
    end else idle_cycles <= idle_cycles + 1;
  end

  // Write one register, then release the channel for a cycle.
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] val);
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Present one word and hold it until taken; valid stays high afterwards.
  task automatic send_tick(tick_t t);
    throttle_i <= t.thr;
    pitch_target_i <= t.pt; pitch_angle_i <= t.pa;
    roll_target_i <= t.rt; roll_angle_i <= t.ra;
    yaw_correction_i <= t.yaw;
    elapsed_ms_i <= t.ms;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    board.note_tick(t);
  endtask

  // Drain expected words, then allow the block to settle before config.
  task automatic drain();
    in_valid_i <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  function automatic logic signed [AngleW-1:0] rand_angle();
    case ($urandom_range(0, 5))
      0: return -9'sd180;
      1: return 9'sd180;
      2: return $signed(9'($urandom));
      default: return $signed(9'($urandom_range(0, 40) - 20));
    endcase
  endfunction

  function automatic tick_t make_tick();
    tick_t t;
    t.thr = ($urandom_range(0, 9) == 0) ? 12'($urandom) : 12'($urandom_range(900, 1800));
    t.pt = rand_angle(); t.pa = rand_angle();
    t.rt = rand_angle(); t.ra = rand_angle();
    t.yaw = ($urandom_range(0, 4) == 0) ? 11'($urandom) : 11'($urandom_range(0, 200) - 100);
    case ($urandom_range(0, 5))
      0: t.ms = 10'($urandom);
      1: t.ms = 10'd0;
      default: t.ms = 10'($urandom_range(1, 20));
    endcase
    return t;
  endfunction

  initial begin
    tick_t t;
    int burst;
    logic signed [AngleW-1:0] ang[4];
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset gains, then field extremes.
    ang = '{-9'sd180, 9'sd180, -9'sd256, 9'sd255};
    for (int k = 0; k < 4; k++) begin
      t = '{thr: 12'd1300, pt: ang[k], pa: ang[3-k], rt: ang[3-k], ra: ang[k],
            yaw: (k[0] ? 11'sd1023 : -11'sd1024), ms: (k == 2 ? 10'd0 : 10'd1023)};
      send_tick(t);
    end
    t = '{thr: 12'd4095, pt: '0, pa: '0, rt: '0, ra: '0, yaw: '0, ms: 10'd1};
    send_tick(t);
    t.thr = 12'd0;
    send_tick(t);
    drain();

    // Large gains drive the outputs into saturation; min above max.
    write_reg(RegPropGain, 16'hFFFF);
    write_reg(RegIntegGain, 16'hFFFF);
    write_reg(RegDerivGain, 16'hFFFF);
    write_reg(RegMinPulse, 16'd2000);
    write_reg(RegMaxPulse, 16'd1500);
    for (int k = 0; k < 12; k++) begin
      t = '{thr: 12'd1500, pt: 9'sd180, pa: -9'sd180, rt: -9'sd180, ra: 9'sd180,
            yaw: 11'sd5, ms: (k == 6 ? 10'd0 : 10'd1023)};
      send_tick(t);
    end
    drain();

    // Random phases with several register settings.
    for (int ph = 0; ph < 5; ph++) begin
      stall_en = (ph != 2);
      write_reg(RegPropGain, ph == 0 ? 16'h0000 : 16'($urandom_range(0, 2048)));
      write_reg(RegIntegGain, ph == 4 ? 16'hFFFF : 16'($urandom_range(0, 512)));
      write_reg(RegDerivGain, ph == 3 ? 16'hFFFF : 16'($urandom_range(0, 64)));
      write_reg(RegMinPulse, ph == 1 ? 16'd0 : 16'($urandom_range(800, 1200)));
      write_reg(RegMaxPulse, ph == 1 ? 16'hFFFF : 16'($urandom_range(1500, 2200)));
      for (int n = 0; n < 200; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 200; b++, n++)
          send_tick(make_tick());
        // idle between bursts, except in phase 2
        if (ph != 2 && n < 200) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          repeat ($urandom_range(0, 30)) @(posedge clk_i);
        end
      end
      drain();
    end

    if (board.mismatches == 0 && board.pending.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule

/* filelist.f */
+incdir+hdl
hdl/qapm_pkg.sv
hdl/qapm_serial_unit.sv
hdl/quad_attitude_pid_mixer.sv
tb/tb.sv
